[design/crrt_pkg.sv]
// ----------------------------------------------------------------------------
// crrt_pkg
// Shared types, widths and constants of the Catmull-Rom ribbon tessellator.
// ----------------------------------------------------------------------------
package crrt_pkg;

  // Default sizes of the sample store and of one frame's output.
  localparam int MAX_SAMPLES_DEF = 32;
  localparam int MAX_PAIRS_DEF   = 32;

  // Field and register widths.
  localparam int INTERVAL_W = 20;
  localparam int LIFETIME_W = 24;
  localparam int SEG_W      = 5;
  localparam int LIMIT_W    = 6;
  localparam int ELAPSED_W  = 20;
  localparam int COORD_W    = 32;
  localparam int TEX_W      = 17;
  localparam int AGE_W      = 24;
  localparam int LANES      = 6;
  localparam int PT_W       = LANES * COORD_W;

  localparam logic [AGE_W-1:0] AGE_SAT = {AGE_W{1'b1}};

  // Register reset values.
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd16000;
  localparam logic [LIFETIME_W-1:0] LIFETIME_RST = 24'd500000;
  localparam logic [SEG_W-1:0]      SEGMENTS_RST = 5'd4;
  localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 6'd32;

  // Configuration port.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_INTERVAL = 2'd0,
    REG_LIFETIME = 2'd1,
    REG_SEGMENTS = 2'd2,
    REG_LIMIT    = 2'd3
  } reg_idx_t;

  typedef enum logic {
    KIND_ADD   = 1'b0,
    KIND_FRAME = 1'b1
  } kind_t;

  // Spline arithmetic widths (segments up to 31 after masking).
  localparam int FACT_W = 15;  // j*s^2, j^2*s, j^3, s^3
  localparam int COEF_W = 36;  // cubic coefficients
  localparam int NUM_W  = 54;  // numerator before division
  localparam int QUO_W  = 53;  // dividend magnitude bits, one per divider step
  localparam int REM_W  = 17;  // partial remainder
  localparam int DVS_W  = 16;  // divisor 2*s^3

  localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

endpackage

[design/catmull_rom_ribbon_tessellator.sv]
// ----------------------------------------------------------------------------
// catmull_rom_ribbon_tessellator
// Ribbon trail sample store with Catmull-Rom vertex pair generation.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the in_ channel (valid/stall); an item is taken at a
// clock edge where in_valid is high and in_stall is low. An add-sample item
// advances the interval timer and may store its two points; it completes in
// the cycle of its transfer and produces no result. A frame-update item ages
// every stored sample (one memory read and one write back per sample), drops
// the expired ones, and, with at least two samples left, emits vertex pairs
// on the out_ channel, one transfer per pair, the last flagged by out_last_pair.
// Each pair is computed with the 53-step restoring divider that scales the
// spline numerator; each new sample first fetches its four neighbour points
// from the point memory and forms the cubic coefficients. A full frame holds
// up to 32 pairs. in_stall stays high while a frame update is in progress,
// so one item is worked on at a time.
// When the receiver holds out_stall, the pair stays on the outputs unchanged
// and the block waits. Reset (rst_n low, synchronous) empties the store,
// clears the timer and restores the register defaults; the memories are not
// cleared, since only entries that were written are ever read. Registers are
// to be written via the APB port only while the block is idle; unchecked.
// ----------------------------------------------------------------------------
module catmull_rom_ribbon_tessellator #(
  parameter int MAX_SAMPLES = crrt_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_PAIRS   = crrt_pkg::MAX_PAIRS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_kind,
  input  logic        [crrt_pkg::ELAPSED_W-1:0] in_elapsed,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_upper_x,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_upper_y,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_upper_z,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_lower_x,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_lower_y,
  input  logic signed [crrt_pkg::COORD_W-1:0]   in_lower_z,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_upper_x,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_upper_y,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_upper_z,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_lower_x,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_lower_y,
  output logic signed [crrt_pkg::COORD_W-1:0]   out_lower_z,
  output logic        [crrt_pkg::TEX_W-1:0]     out_tex_v,
  output logic                                  out_last_pair,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [crrt_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic        [crrt_pkg::CFG_DATA_W-1:0] pwdata,
  output logic        [crrt_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);

  localparam int SW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = $clog2(MAX_PAIRS + 1);
  localparam int LN = crrt_pkg::LANES;
  localparam int TL = crrt_pkg::LANES;      // the tex_v divider lane
  localparam int FW = crrt_pkg::FACT_W;
  localparam int NW = crrt_pkg::NUM_W;
  localparam int QW = crrt_pkg::QUO_W;
  localparam int RW = crrt_pkg::REM_W;
  localparam int DW = crrt_pkg::DVS_W;
  localparam int KW = crrt_pkg::COEF_W;
  localparam int XW = crrt_pkg::COORD_W;
  localparam int AW = crrt_pkg::AGE_W;
  localparam int PROD_W = CW + crrt_pkg::SEG_W;
  localparam int DCW = $clog2(QW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_AGE_RD, ST_AGE_WR, ST_PRUNE, ST_SETUP1, ST_SETUP2, ST_FETCH,
    ST_COEF, ST_JP1, ST_JP2, ST_MUL, ST_SUM, ST_DIV, ST_FIN, ST_OUT
  } state_t;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  // Ring slot of the sample 'off' places after 'base'.
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    begin
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(MAX_SAMPLES)) begin
        sum = sum - (CW+1)'(MAX_SAMPLES);
      end
      return sum[SW-1:0];
    end
  endfunction

  // Saturating 24-bit time accumulation.
  function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a,
                                            input logic [crrt_pkg::ELAPSED_W-1:0] b);
    logic [AW:0] s;
    begin
      s = (AW+1)'(a) + (AW+1)'(b);
      return s[AW] ? crrt_pkg::AGE_SAT : s[AW-1:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [crrt_pkg::INTERVAL_W-1:0] interval_r;
  logic [crrt_pkg::LIFETIME_W-1:0] lifetime_r;
  logic [crrt_pkg::SEG_W-1:0]      segments_r;
  logic [crrt_pkg::LIMIT_W-1:0]    limit_r;
  logic                            cfg_wr;
  crrt_pkg::reg_idx_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = crrt_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= crrt_pkg::INTERVAL_RST;
      lifetime_r <= crrt_pkg::LIFETIME_RST;
      segments_r <= crrt_pkg::SEGMENTS_RST;
      limit_r    <= crrt_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        crrt_pkg::REG_INTERVAL: interval_r <= pwdata[crrt_pkg::INTERVAL_W-1:0];
        crrt_pkg::REG_LIFETIME: lifetime_r <= pwdata[crrt_pkg::LIFETIME_W-1:0];
        crrt_pkg::REG_SEGMENTS: segments_r <= pwdata[crrt_pkg::SEG_W-1:0];
        crrt_pkg::REG_LIMIT:    limit_r    <= pwdata[crrt_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      crrt_pkg::REG_INTERVAL: prdata = crrt_pkg::CFG_DATA_W'(interval_r);
      crrt_pkg::REG_LIFETIME: prdata = crrt_pkg::CFG_DATA_W'(lifetime_r);
      crrt_pkg::REG_SEGMENTS: prdata = crrt_pkg::CFG_DATA_W'(segments_r);
      crrt_pkg::REG_LIMIT:    prdata = crrt_pkg::CFG_DATA_W'(limit_r);
      default:                prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  state_t            state_r;
  logic [AW-1:0]     timer_r;
  logic [SW-1:0]     oldest_r;
  logic [CW-1:0]     count_r;
  logic [crrt_pkg::ELAPSED_W-1:0] elapsed_r;
  logic [CW-1:0]     idx_r;       // ageing index, then sample index
  logic [CW-1:0]     rm_r;        // samples found expired
  logic [SW-1:0]     age_slot_r;
  logic [2:0]        fetch_r;
  logic [crrt_pkg::SEG_W-1:0] j_r;
  logic [crrt_pkg::SEG_W-1:0] s_r;
  logic [PW-1:0]     k_r;
  logic [PW-1:0]     np_r;
  logic [DCW-1:0]    div_cnt_r;
  logic              out_valid_r;

  // Memories
  logic                  pt_we, age_we;
  logic [SW-1:0]         pt_waddr, pt_raddr, age_waddr, age_raddr;
  logic [crrt_pkg::PT_W-1:0] pt_wdata, pt_rdata;
  logic [AW-1:0]         age_wdata, age_rdata;

  crrt_ram #(.WIDTH(crrt_pkg::PT_W), .DEPTH(MAX_SAMPLES)) u_pt_ram (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  crrt_ram #(.WIDTH(AW), .DEPTH(MAX_SAMPLES)) u_age_ram (
    .clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
    .raddr(age_raddr), .rdata(age_rdata)
  );

  // Add-sample decisions, taken in the transfer cycle.
  logic          in_xfer, add_go;
  logic [AW-1:0] timer_sum;
  logic          full;
  logic [SW-1:0] oldest_add;
  logic [CW-1:0] count_base;
  logic [SW-1:0] wslot;
  logic [AW-1:0] age_new;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign timer_sum = sat_add(timer_r, in_elapsed);
  assign add_go    = in_xfer && (in_kind == crrt_pkg::KIND_ADD) &&
                     (timer_sum > AW'(interval_r));
  assign full       = (count_r == CW'(MAX_SAMPLES));
  assign oldest_add = full ? slot_of(oldest_r, CW'(1)) : oldest_r;
  assign count_base = full ? count_r - CW'(1) : count_r;
  assign wslot      = slot_of(oldest_add, count_base);
  assign age_new    = sat_add(age_rdata, elapsed_r);

  // Neighbour indices, clamped at both ends of the trail.
  logic [CW:0]   idx_p1, idx_p2;
  logic [CW-1:0] i0, i2, i3, fetch_idx;

  assign idx_p1 = (CW+1)'(idx_r) + (CW+1)'(1);
  assign idx_p2 = (CW+1)'(idx_r) + (CW+1)'(2);
  assign i0 = (idx_r == '0) ? '0 : idx_r - CW'(1);
  assign i2 = (idx_p1 >= (CW+1)'(count_r)) ? idx_r : idx_p1[CW-1:0];
  assign i3 = (idx_p2 >= (CW+1)'(count_r)) ? i2 : idx_p2[CW-1:0];

  always_comb begin
    case (fetch_r[1:0])
      2'd0:    fetch_idx = i0;
      2'd1:    fetch_idx = idx_r;
      2'd2:    fetch_idx = i2;
      default: fetch_idx = i3;
    endcase
  end

  always_comb begin
    pt_we     = add_go;
    pt_waddr  = wslot;
    pt_wdata  = {in_lower_z, in_lower_y, in_lower_x, in_upper_z, in_upper_y, in_upper_x};
    pt_raddr  = slot_of(oldest_r, fetch_idx);
    age_raddr = slot_of(oldest_r, idx_r);
    if (state_r == ST_AGE_WR) begin
      age_we    = 1'b1;
      age_waddr = age_slot_r;
      age_wdata = age_new;
    end else begin
      age_we    = add_go;
      age_waddr = wslot;
      age_wdata = '0;
    end
  end

  // Frame set-up arithmetic.
  logic [crrt_pkg::SEG_W-1:0] seg_eff;
  logic [PW-1:0]              limit_eff;
  logic [PROD_W-1:0]          pair_prod;
  logic [CW-1:0]              count_left;

  assign seg_eff    = (segments_r == '0) ? crrt_pkg::SEG_W'(1) : segments_r;
  assign pair_prod  = PROD_W'(count_r) * PROD_W'(seg_eff);
  assign count_left = count_r - rm_r;

  always_comb begin
    if (limit_r < crrt_pkg::LIMIT_W'(2)) begin
      limit_eff = PW'(2);
    end else if (limit_r > crrt_pkg::LIMIT_W'(MAX_PAIRS)) begin
      limit_eff = PW'(MAX_PAIRS);
    end else begin
      limit_eff = limit_r[PW-1:0];
    end
  end

  logic last_k;
  assign last_k = (k_r == np_r - PW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      timer_r     <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            elapsed_r <= in_elapsed;
            idx_r     <= '0;
            rm_r      <= '0;
            if (in_kind == crrt_pkg::KIND_ADD) begin
              if (add_go) begin
                oldest_r <= oldest_add;
                count_r  <= count_base + CW'(1);
                timer_r  <= '0;
              end else begin
                timer_r  <= timer_sum;
              end
            end else begin
              state_r <= (count_r == '0) ? ST_PRUNE : ST_AGE_RD;
            end
          end
        end
        ST_AGE_RD: begin
          age_slot_r <= slot_of(oldest_r, idx_r);
          state_r    <= ST_AGE_WR;
        end
        ST_AGE_WR: begin
          // Ages stay ordered, so the expired samples are the oldest ones.
          if (age_new >= lifetime_r) begin
            rm_r <= rm_r + CW'(1);
          end
          idx_r   <= idx_r + CW'(1);
          state_r <= (idx_p1 == (CW+1)'(count_r)) ? ST_PRUNE : ST_AGE_RD;
        end
        ST_PRUNE: begin
          oldest_r <= slot_of(oldest_r, rm_r);
          count_r  <= count_left;
          state_r  <= (count_left < CW'(2)) ? ST_IDLE : ST_SETUP1;
        end
        ST_SETUP1: begin
          s_r  <= seg_eff;
          np_r <= (pair_prod < PROD_W'(limit_eff)) ? pair_prod[PW-1:0] : limit_eff;
          state_r <= ST_SETUP2;
        end
        ST_SETUP2: begin
          idx_r   <= '0;
          j_r     <= '0;
          k_r     <= '0;
          fetch_r <= '0;
          state_r <= ST_FETCH;
        end
        ST_FETCH: begin
          fetch_r <= fetch_r + 3'd1;
          if (fetch_r == 3'd4) begin
            state_r <= ST_COEF;
          end
        end
        ST_COEF: state_r <= ST_JP1;
        ST_JP1:  state_r <= ST_JP2;
        ST_JP2:  state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_SUM;
        ST_SUM: begin
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(QW - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (last_k) begin
              state_r <= ST_IDLE;
            end else begin
              k_r <= k_r + PW'(1);
              if (j_r + crrt_pkg::SEG_W'(1) == s_r) begin
                j_r     <= '0;
                idx_r   <= idx_r + CW'(1);
                fetch_r <= '0;
                state_r <= ST_FETCH;
              end else begin
                j_r     <= j_r + crrt_pkg::SEG_W'(1);
                state_r <= ST_JP1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------------
  // Spline datapath
  // ---------------------------------------------------------------------
  // Each coordinate is floor((N + s^3) / (2 s^3)) with
  // N = 2 P1 s^3 + A j s^2 + B j^2 s + C j^3. The sample's own pair is the
  // case j = 0, which gives P1 exactly.
  logic [crrt_pkg::PT_W-1:0] p_r [4];
  logic signed [KW-1:0]      ca_r [LN];
  logic signed [KW-1:0]      cb_r [LN];
  logic signed [KW-1:0]      cc_r [LN];
  logic [FW-1:0]             s2_r, s3_r, j2_r, j3_r, js2_r, j2s_r;
  logic [DW-1:0]             dd_r, tex_den_r;
  logic signed [NW-1:0]      t1_r [LN];
  logic signed [NW-1:0]      ta_r [LN];
  logic signed [NW-1:0]      tb_r [LN];
  logic signed [NW-1:0]      tc_r [LN];
  logic [PW+15:0]            tex_num_r;
  logic [QW-1:0]             quo_r [LN+1];
  logic [RW-1:0]             rem_r [LN+1];
  logic                      neg_r [LN];

  logic signed [XW-1:0]      pc [4][LN];
  logic signed [XW+15:0]     t1_w [LN];
  logic signed [KW+15:0]     ta_w [LN];
  logic signed [KW+15:0]     tb_w [LN];
  logic signed [KW+15:0]     tc_w [LN];
  logic signed [NW-1:0]      m_w [LN];
  logic [QW-1:0]             quo_nxt [LN+1];
  logic [RW-1:0]             rem_nxt [LN+1];
  logic [XW-1:0]             res_w [LN];

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      for (int l = 0; l < LN; l++) begin
        pc[f][l] = $signed(p_r[f][l*XW +: XW]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LN; l++) begin
      t1_w[l] = pc[1][l] * $signed({1'b0, s3_r});
      ta_w[l] = ca_r[l] * $signed({1'b0, js2_r});
      tb_w[l] = cb_r[l] * $signed({1'b0, j2s_r});
      tc_w[l] = cc_r[l] * $signed({1'b0, j3_r});
      m_w[l]  = (t1_r[l] <<< 1) + ta_r[l] + tb_r[l] + tc_r[l] + NW'($signed({1'b0, s3_r}));
    end
  end

  // One restoring division step per lane.
  logic [RW-1:0] trial [LN+1];
  logic [DW-1:0] dvs   [LN+1];
  always_comb begin
    for (int l = 0; l <= LN; l++) begin
      dvs[l]   = (l == TL) ? tex_den_r : dd_r;
      trial[l] = {rem_r[l][RW-2:0], quo_r[l][QW-1]};
      if (trial[l] >= RW'(dvs[l])) begin
        rem_nxt[l] = trial[l] - RW'(dvs[l]);
        quo_nxt[l] = {quo_r[l][QW-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[l];
        quo_nxt[l] = {quo_r[l][QW-2:0], 1'b0};
      end
    end
  end

  // Sign, floor correction and saturation to 32 bits.
  logic [QW:0] qc [LN];
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      qc[l] = (QW+1)'(quo_r[l]) + (QW+1)'(rem_r[l] != '0);
      if (!neg_r[l]) begin
        res_w[l] = (quo_r[l] > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_r[l][XW-1:0];
      end else begin
        res_w[l] = (qc[l] > (QW+1)'(32'h8000_0000)) ? 32'h8000_0000
                                                    : XW'(-qc[l][XW-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_SETUP1: s2_r <= FW'(seg_eff) * FW'(seg_eff);
      ST_SETUP2: begin
        s3_r      <= s2_r * FW'(s_r);
        dd_r      <= {DW'(s2_r * FW'(s_r))} << 1;
        tex_den_r <= DW'(np_r - PW'(1));
      end
      ST_FETCH: begin
        if (fetch_r != 3'd0) begin
          p_r[2'(fetch_r - 3'd1)] <= pt_rdata;
        end
      end
      ST_COEF: begin
        for (int l = 0; l < LN; l++) begin
          ca_r[l] <= KW'(pc[2][l]) - KW'(pc[0][l]);
          cb_r[l] <= (KW'(pc[0][l]) <<< 1) - (KW'(pc[1][l]) <<< 2) - KW'(pc[1][l])
                   + (KW'(pc[2][l]) <<< 2) - KW'(pc[3][l]);
          cc_r[l] <= KW'(pc[1][l]) - KW'(pc[0][l]) + (KW'(pc[1][l]) <<< 1)
                   - (KW'(pc[2][l]) <<< 1) - KW'(pc[2][l]) + KW'(pc[3][l]);
        end
      end
      ST_JP1: begin
        j2_r  <= FW'(j_r) * FW'(j_r);
        js2_r <= FW'(j_r) * s2_r;
      end
      ST_JP2: begin
        j3_r  <= j2_r * FW'(j_r);
        j2s_r <= j2_r * FW'(s_r);
      end
      ST_MUL: begin
        for (int l = 0; l < LN; l++) begin
          t1_r[l] <= NW'(t1_w[l]);
          ta_r[l] <= NW'(ta_w[l]);
          tb_r[l] <= NW'(tb_w[l]);
          tc_r[l] <= NW'(tc_w[l]);
        end
        tex_num_r <= {k_r, 16'd0} + (PW+16)'(tex_den_r[DW-1:1]);
      end
      ST_SUM: begin
        for (int l = 0; l < LN; l++) begin
          neg_r[l] <= m_w[l][NW-1];
          quo_r[l] <= m_w[l][NW-1] ? QW'(-m_w[l]) : QW'(m_w[l]);
          rem_r[l] <= '0;
        end
        quo_r[TL] <= QW'(tex_num_r);
        rem_r[TL] <= '0;
      end
      ST_DIV: begin
        for (int l = 0; l <= LN; l++) begin
          quo_r[l] <= quo_nxt[l];
          rem_r[l] <= rem_nxt[l];
        end
      end
      ST_FIN: begin
        out_upper_x   <= res_w[0];
        out_upper_y   <= res_w[1];
        out_upper_z   <= res_w[2];
        out_lower_x   <= res_w[3];
        out_lower_y   <= res_w[4];
        out_lower_z   <= res_w[5];
        out_tex_v     <= crrt_pkg::TEX_ONE - quo_r[TL][crrt_pkg::TEX_W-1:0];
        out_last_pair <= last_k;
      end
      default: ;
    endcase
  end

endmodule

[design/crrt_ram.sv]
// ----------------------------------------------------------------------------
// crrt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crrt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/crrt_checker.sv]
// ----------------------------------------------------------------------------
// crrt_checker
// Port-level checks of the ribbon tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module crrt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                in_kind,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [crrt_pkg::COORD_W-1:0] out_upper_x,
  input logic        [crrt_pkg::TEX_W-1:0]   out_tex_v,
  input logic                                out_last_pair
);

  // A frame update occupies the block: no further input in the next cycle.
  a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == crrt_pkg::KIND_FRAME |=> in_stall)
    else $error("input taken straight after a frame update");

  // Results only appear while a frame update is in progress.
  a_out_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("result offered while the input side is open");

  // The final pair ends the frame's output.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_pair |=> !out_valid)
    else $error("result offered after the final pair");

  // A stalled result is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_upper_x) && $stable(out_tex_v))
    else $error("stalled result changed");

endmodule

bind catmull_rom_ribbon_tessellator crrt_checker u_crrt_checker (.*);

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ribbon tessellator testbench
// Sends add-sample and frame-update items through the input channel, keeps
// its own copy of the sample store and registers, works out every vertex
// pair a frame update should give and checks each pair the block returns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NSLOT = 32;
  localparam int NPAIR = 32;

  // One input item as it is put on the in_ ports.
  typedef struct packed {
    logic        kind;
    logic [19:0] elapsed;
    logic [31:0] ux, uy, uz, lx, ly, lz;
  } ribbon_item_t;

  // One vertex pair as the out_ ports carry it.
  typedef struct packed {
    logic [31:0] ux, uy, uz, lx, ly, lz;
    logic [16:0] tex_v;
    logic        last;
  } vertex_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [19:0] in_elapsed = '0;
  logic signed [31:0] in_upper_x = '0, in_upper_y = '0, in_upper_z = '0;
  logic signed [31:0] in_lower_x = '0, in_lower_y = '0, in_lower_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_upper_x, out_upper_y, out_upper_z;
  logic signed [31:0] out_lower_x, out_lower_y, out_lower_z;
  logic [16:0] out_tex_v;
  logic out_last_pair;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [crrt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  catmull_rom_ribbon_tessellator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_elapsed(in_elapsed),
    .in_upper_x(in_upper_x), .in_upper_y(in_upper_y), .in_upper_z(in_upper_z),
    .in_lower_x(in_lower_x), .in_lower_y(in_lower_y), .in_lower_z(in_lower_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_upper_x(out_upper_x), .out_upper_y(out_upper_y),
    .out_upper_z(out_upper_z), .out_lower_x(out_lower_x),
    .out_lower_y(out_lower_y), .out_lower_z(out_lower_z),
    .out_tex_v(out_tex_v), .out_last_pair(out_last_pair),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Predictor state: registers and the sample ring.
  logic [19:0] m_interval;
  logic [23:0] m_lifetime;
  logic [4:0]  m_segments;
  logic [5:0]  m_limit;
  logic [23:0] m_timer;
  logic [31:0] m_pt[NSLOT][6];
  logic [23:0] m_age[NSLOT];
  int          m_oldest, m_count;

  ribbon_item_t pending_items[$];
  vertex_pair_t expected_pairs[$];
  int errors = 0;
  int pairs_seen = 0;
  int frames_sent = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_receiver = 1'b0;
  bit driver_on = 1'b0;
  bit in_taken = 1'b0;

  function automatic logic [23:0] add_sat24(logic [23:0] a, logic [19:0] b);
    logic [24:0] s;
    s = {1'b0, a} + b;
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic int slot(int logical);
    return (m_oldest + logical) % NSLOT;
  endfunction

  // Exact Catmull-Rom value at t = j/s, rounded half up, saturated to 32 bits.
  function automatic logic [31:0] spline_point(longint p0, longint p1, longint p2,
                                               longint p3, longint j, longint s);
    longint s3, n, d, q;
    s3 = s * s * s;
    n = 2 * p1 * s3 + (p2 - p0) * j * s * s
      + (2 * p0 - 5 * p1 + 4 * p2 - p3) * j * j * s
      + (-p0 + 3 * p1 - 3 * p2 + p3) * j * j * j + s3;
    d = 2 * s3;
    q = (n >= 0) ? n / d : -((-n + d - 1) / d);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  // Applies one accepted item to the predictor and queues the pairs it gives.
  task automatic tessellate(ribbon_item_t it);
    int lim, segs, np, a, b0, b2, b3, i0, i2, i3, w;
    longint den;
    vertex_pair_t frame[$];
    vertex_pair_t vp;
    logic [31:0] v[6];
    if (it.kind == crrt_pkg::KIND_ADD) begin
      m_timer = add_sat24(m_timer, it.elapsed);
      if (m_timer > {4'd0, m_interval}) begin
        if (m_count >= NSLOT) begin
          m_oldest = (m_oldest + 1) % NSLOT;
          m_count--;
        end
        w = slot(m_count);
        m_pt[w][0] = it.ux; m_pt[w][1] = it.uy; m_pt[w][2] = it.uz;
        m_pt[w][3] = it.lx; m_pt[w][4] = it.ly; m_pt[w][5] = it.lz;
        m_age[w] = '0;
        m_count++;
        m_timer = '0;
      end
      return;
    end
    frames_sent++;
    for (int i = 0; i < m_count; i++) m_age[slot(i)] = add_sat24(m_age[slot(i)], it.elapsed);
    while (m_count > 0 && m_age[m_oldest] >= m_lifetime) begin
      m_oldest = (m_oldest + 1) % NSLOT;
      m_count--;
    end
    if (m_count < 2) return;
    lim = (m_limit < 2) ? 2 : (m_limit > NPAIR) ? NPAIR : m_limit;
    segs = (m_segments == 0) ? 1 : m_segments;
    np = 0;
    for (int i = 0; i < m_count && np < lim; i++) begin
      i0 = (i == 0) ? 0 : i - 1;
      i2 = (i + 1 >= m_count) ? i : i + 1;
      i3 = (i + 2 >= m_count) ? i2 : i + 2;
      a = slot(i); b0 = slot(i0); b2 = slot(i2); b3 = slot(i3);
      for (int j = 0; j < segs && np < lim; j++) begin
        for (int c = 0; c < 6; c++)
          v[c] = (j == 0) ? m_pt[a][c] :
                 spline_point($signed(m_pt[b0][c]), $signed(m_pt[a][c]),
                              $signed(m_pt[b2][c]), $signed(m_pt[b3][c]), j, segs);
        vp = '{v[0], v[1], v[2], v[3], v[4], v[5], 17'd0, 1'b0};
        frame.push_back(vp);
        np++;
      end
    end
    den = np - 1;
    foreach (frame[k]) begin
      frame[k].tex_v = 17'(65536 - ((longint'(k) * 65536 + den / 2) / den));
      frame[k].last = (k == np - 1);
      expected_pairs.push_back(frame[k]);
    end
  endtask

  // Driver: takes items from the pending queue, changes inputs at the falling edge.
  // A new item is offered only once the one on the ports has been transferred.
  always @(negedge clk) begin
    ribbon_item_t it;
    if (driver_on && (!in_valid || in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        in_kind <= it.kind; in_elapsed <= it.elapsed;
        in_upper_x <= it.ux; in_upper_y <= it.uy; in_upper_z <= it.uz;
        in_lower_x <= it.lx; in_lower_y <= it.ly; in_lower_z <= it.lz;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= hold_receiver || ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: the predictor follows each input transfer; each result transfer
  // is compared field by field with the oldest expected pair.
  always @(posedge clk) begin
    vertex_pair_t got, want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      tessellate('{in_kind, in_elapsed, in_upper_x, in_upper_y, in_upper_z,
                   in_lower_x, in_lower_y, in_lower_z});
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_upper_x, out_upper_y, out_upper_z, out_lower_x, out_lower_y,
              out_lower_z, out_tex_v, out_last_pair};
      pairs_seen++;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected pair %h", $time, got);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.ux !== want.ux) $display("%0t: upper_x exp %h got %h", $time, want.ux, got.ux);
        if (got.uy !== want.uy) $display("%0t: upper_y exp %h got %h", $time, want.uy, got.uy);
        if (got.uz !== want.uz) $display("%0t: upper_z exp %h got %h", $time, want.uz, got.uz);
        if (got.lx !== want.lx) $display("%0t: lower_x exp %h got %h", $time, want.lx, got.lx);
        if (got.ly !== want.ly) $display("%0t: lower_y exp %h got %h", $time, want.ly, got.ly);
        if (got.lz !== want.lz) $display("%0t: lower_z exp %h got %h", $time, want.lz, got.lz);
        if (got.tex_v !== want.tex_v)
          $display("%0t: tex_v exp %0d got %0d", $time, want.tex_v, got.tex_v);
        if (got.last !== want.last)
          $display("%0t: last_pair exp %b got %b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  // Register write: setup cycle then access cycle, predictor updated alongside.
  task automatic write_reg(crrt_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= crrt_pkg::CFG_ADDR_W'(idx * 4); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      crrt_pkg::REG_INTERVAL: m_interval = value[19:0];
      crrt_pkg::REG_LIFETIME: m_lifetime = value[23:0];
      crrt_pkg::REG_SEGMENTS: m_segments = value[4:0];
      crrt_pkg::REG_LIMIT:    m_limit = value[5:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Waits until every queued item is taken and every expected pair has come,
  // then lets a frame's worth of cycles pass so the block is surely idle.
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (2500) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_add(logic [19:0] el);
    pending_items.push_back('{crrt_pkg::KIND_ADD, el, rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), rand_coord(), rand_coord()});
  endtask

  task automatic push_frame(logic [19:0] el);
    pending_items.push_back('{crrt_pkg::KIND_FRAME, el, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom});
  endtask

  // A random burst: mostly samples that get stored, a frame update now and then.
  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1:    push_frame(20'($urandom_range(0, 3) == 0 ? $urandom
                                                          : $urandom_range(0, 20000)));
        2:       push_add(20'($urandom));
        default: push_add(20'(m_interval + 1 + $urandom_range(0, 100)));
      endcase
    end
  endtask

  initial begin
    m_interval = crrt_pkg::INTERVAL_RST; m_lifetime = crrt_pkg::LIFETIME_RST;
    m_segments = crrt_pkg::SEGMENTS_RST; m_limit = crrt_pkg::LIMIT_RST;
    m_timer = '0; m_oldest = 0; m_count = 0;
    foreach (m_age[i]) m_age[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    driver_on = 1'b1;

    // Directed: defaults, empty and single-sample frames, the interval edge,
    // then a short ribbon at extreme coordinates.
    push_frame(20'd10);
    push_add(20'd16000);               // equal to the interval: not stored
    push_add(20'd1);                   // now exceeds it
    push_frame(20'd0);                 // one sample only: no pairs
    push_add(20'hFFFFF);
    pending_items.push_back('{crrt_pkg::KIND_ADD, 20'hFFFFF, 32'h7FFFFFFF, 32'h80000000,
                              32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000});
    pending_items.push_back('{crrt_pkg::KIND_ADD, 20'hFFFFF, 32'h80000000, 32'h7FFFFFFF,
                              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF});
    push_add(20'hFFFFF);
    push_frame(20'd5);
    drain();

    // Smallest settings: zero interval, zero segments counted as one, limit below two.
    write_reg(crrt_pkg::REG_INTERVAL, 32'h0);
    write_reg(crrt_pkg::REG_SEGMENTS, 32'h0);
    write_reg(crrt_pkg::REG_LIMIT, 32'h1);
    push_add(20'd1); push_add(20'd1); push_add(20'd1);
    push_frame(20'd1);
    drain();
    // Widest lifetime: samples last until their ages saturate.
    write_reg(crrt_pkg::REG_LIFETIME, 32'hFFFFFFFF);
    write_reg(crrt_pkg::REG_SEGMENTS, 32'd16);
    write_reg(crrt_pkg::REG_LIMIT, 32'd63);      // above the maximum: clamped
    push_frame(20'hFFFFF);
    for (int i = 0; i < 17; i++) push_frame(20'hFFFFF);
    drain();
    write_reg(crrt_pkg::REG_LIFETIME, 32'h0);    // everything removed at the next frame
    push_frame(20'd0);
    push_add(20'd3); push_add(20'd3);
    push_frame(20'd0);
    drain();

    // Random phases over several register settings and idling patterns.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(crrt_pkg::REG_INTERVAL, ph == 5 ? 32'hFFFFF : $urandom_range(0, 5000));
      write_reg(crrt_pkg::REG_LIFETIME, ph == 4 ? 32'd1 : $urandom_range(20000, 400000));
      write_reg(crrt_pkg::REG_SEGMENTS, $urandom_range(0, 16));
      write_reg(crrt_pkg::REG_LIMIT, $urandom_range(2, 32));
      send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 64 : 0;
      recv_idle_pct = (ph < 2) ? 64 : (ph < 4) ? 8 : 0;
      random_burst(45);
      if (ph == 2) begin
        // Long receiver hold-off while the sender keeps offering items.
        hold_receiver = 1'b1;
        fork
          begin
            repeat (3000) @(posedge clk);
            hold_receiver = 1'b0;
          end
        join_none
      end
      drain();                          // sender pauses until all pairs are in
      wait (!hold_receiver);
    end

    $display("Run covered %0d frame updates and %0d checked vertex pairs,", frames_sent,
             pairs_seen);
    $display("with interval, lifetime, segment and limit extremes and both idling patterns.");
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
